// ===== sv/denv_pkg.sv =====
`default_nettype none

package denv_pkg;

  localparam int unsigned ShapeTableSize = 256;
  localparam int unsigned CoeffFracBits = 24;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW = 16;
  localparam int unsigned CoeffW = 24;
  localparam int unsigned AmountW = 17;
  localparam int unsigned EnvW = 17;
  localparam int unsigned CfgW = 24;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned LvlFrac = 24;
  localparam int unsigned LvlW = 29;
  localparam int unsigned SmoothW = 25;
  localparam int unsigned RectShift = 3;
  localparam int unsigned AmountFrac = 16;
  localparam int unsigned OutShift = 8;

  localparam int unsigned MulAW = 29;
  localparam int unsigned MulBW = 24;
  localparam int unsigned ProdW = MulAW + MulBW;
  localparam int unsigned StepW = ProdW - CoeffFracBits;
  localparam int unsigned SumW = ((StepW > LvlW) ? StepW : LvlW) + 1;

  localparam logic [LvlW-1:0] LvlOne = 29'h100_0000;
  localparam logic [LvlW-1:0] LvlMax = 29'h1000_0000;
  localparam logic [AmountW-1:0] AmountFull = 17'h1_0000;
  localparam logic [EnvW-1:0] EnvFull = 17'h1_0000;
  localparam logic [OutShift-1:0] OutRound = 8'h80;

  localparam logic [GainW-1:0] SensGainReset = 16'd4096;
  localparam logic [CoeffW-1:0] FastAttackReset = 24'd87154;
  localparam logic [CoeffW-1:0] FastReleaseReset = 24'd23285;
  localparam logic [CoeffW-1:0] SlowAttackReset = 24'd29102;
  localparam logic [CoeffW-1:0] SlowReleaseReset = 24'd1165;
  localparam logic [CoeffW-1:0] SmoothReset = 24'd173855;
  localparam logic [AmountW-1:0] ShapeAmountReset = 17'd0;

  localparam int unsigned ExpFrac = 28;
  localparam logic [63:0] ExpOne = 64'd1 << ExpFrac;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RECT_MUL,
    ST_RECT_SAT,
    ST_POLE_DIFF,
    ST_POLE_MUL,
    ST_POLE_UPD,
    ST_ENV_MAX,
    ST_POS_MUL,
    ST_TBL_LO,
    ST_TBL_HI,
    ST_INTERP_DIFF,
    ST_INTERP_MUL,
    ST_INTERP_ADD,
    ST_SHAPE_DIFF,
    ST_SHAPE_MUL,
    ST_SHAPE_ADD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    POLE_FAST,
    POLE_SLOW,
    POLE_SMOOTH
  } pole_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENS_GAIN,
    CFG_FAST_ATTACK,
    CFG_FAST_RELEASE,
    CFG_SLOW_ATTACK,
    CFG_SLOW_RELEASE,
    CFG_SMOOTH,
    CFG_SHAPE_AMOUNT
  } cfg_reg_e;

  // The functions below only build the shaping table at elaboration.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int k;
    quo = '0;
    rem = '0;
    for (k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] exp_fixed(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] n;
    sum = ExpOne;
    term = ExpOne;
    for (n = 64'd1; n < 64'd64 && term != 64'd0; n++) begin
      term = udiv64((term * z) >> ExpFrac, n);
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] tanh_half(input logic [63:0] z);
    logic [63:0] e;
    e = exp_fixed(z);
    return udiv64((e - 64'd1) << ExpFrac, e + 64'd1);
  endfunction

  localparam logic [63:0] TanhEnd = tanh_half(64'd3 << ExpFrac);

  function automatic logic [LvlFrac:0] shape_point(input int unsigned idx,
                                                    input int unsigned size);
    logic [63:0] z;
    logic [63:0] t;
    logic [63:0] v;
    if (idx == 0) begin
      return '0;
    end
    if (idx >= size) begin
      return LvlOne[LvlFrac:0];
    end
    z = udiv64((64'd3 << ExpFrac) * 64'(idx), 64'(size));
    t = tanh_half(z);
    v = udiv64((t << LvlFrac) + (TanhEnd >> 1), TanhEnd);
    if (v > 64'(LvlOne)) begin
      v = 64'(LvlOne);
    end
    return v[LvlFrac:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/dual_envelope_follower_unit.sv =====
`default_nettype none

// envelope_o is registered as the sequencer leaves ST_DONE; in_stall_o refuses new samples
// until the sequencer is back in ST_IDLE. A single shared 29x24 multiplier and one
// subtract/compare unit are stepped through the sequence by the state machine.
// A result still held on a stalled output delays only the end of the next sample.
// Reset (rst_ni, asynchronous) clears all follower states to zero and loads the
// configuration registers with their default values; no clearing pass is needed.

module dual_envelope_follower_unit #(
  parameter int unsigned SHAPE_TABLE_SIZE = denv_pkg::ShapeTableSize
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [denv_pkg::SampleW-1:0] sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [denv_pkg::EnvW-1:0]            envelope_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [denv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [denv_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int unsigned LvlW = denv_pkg::LvlW;
  localparam int unsigned SmoothW = denv_pkg::SmoothW;
  localparam int unsigned ProdW = denv_pkg::ProdW;
  localparam int unsigned SumW = denv_pkg::SumW;
  localparam int unsigned MulAW = denv_pkg::MulAW;
  localparam int unsigned MulBW = denv_pkg::MulBW;
  localparam int unsigned LvlFrac = denv_pkg::LvlFrac;
  localparam int unsigned CoeffFracBits = denv_pkg::CoeffFracBits;
  localparam int unsigned AmountFrac = denv_pkg::AmountFrac;
  localparam int unsigned OutShift = denv_pkg::OutShift;
  localparam int unsigned EnvW = denv_pkg::EnvW;
  localparam int unsigned IdxW = $clog2(SHAPE_TABLE_SIZE + 1);
  localparam int unsigned RoundW = SmoothW + 1 - OutShift;
  localparam int unsigned ShStepW = ProdW - AmountFrac;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(SHAPE_TABLE_SIZE);
  localparam logic [SmoothW-1:0] SmoothOne = denv_pkg::LvlOne[SmoothW-1:0];

  denv_pkg::state_e state_q, state_d;
  denv_pkg::pole_e  pass_q, pass_d;
  logic             load_out;

  logic [denv_pkg::GainW-1:0]   sens_gain_q;
  logic [denv_pkg::CoeffW-1:0]  fast_att_q, fast_rel_q, slow_att_q, slow_rel_q, smooth_coef_q;
  logic [denv_pkg::AmountW-1:0] shape_amount_q;

  logic [LvlW-1:0]    fast_q, slow_q;
  logic [SmoothW-1:0] smooth_q;

  logic [denv_pkg::SampleW-1:0] raw, mag, mag_q;
  logic [LvlW-1:0]              rect_q;
  logic [SmoothW-1:0]           env_q, curve_q, shaped_q, tbl_a_q, tbl_b_q;
  logic [LvlFrac-1:0]           frac_q;
  logic [IdxW-1:0]              idx_q;
  logic                         dir_q;
  logic [LvlW-1:0]              dabs_q;
  logic [denv_pkg::CoeffW-1:0]  coef_q, coef_d;
  logic [ProdW-1:0]             prod_q, prod_d;
  logic [EnvW-1:0]              out_q;
  logic                         out_valid_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [LvlW-1:0]  diff_x, diff_y, diff_abs;
  logic             diff_up;
  logic [LvlW-1:0]  pole_st, pole_tgt, pole_lim, pole_new;
  logic [SumW-1:0]  step_ext, st_ext, up_sum;
  logic [denv_pkg::AmountW-1:0] amount;

  logic [ProdW-1:0]   rect_raw;
  logic [LvlW-1:0]    rect_sat;
  logic [LvlW-1:0]    env_max;
  logic [SmoothW-1:0] env_d;
  logic [IdxW-1:0]    pos_idx, hi_addr, rd_addr;
  logic [SmoothW-1:0] tbl_rd;
  logic [LvlW:0]      ip_sum;
  logic [LvlW-1:0]    ip_step;
  logic [ShStepW:0]   sh_step, sh_env, sh_sum;
  logic [SmoothW-1:0] shaped_d;
  logic [SmoothW:0]   out_sum;
  logic [RoundW-1:0]  rounded;
  logic [EnvW-1:0]    env_out;

  // Shaping curve as a constant table built at elaboration.
  logic [SmoothW-1:0] shape_tbl [SHAPE_TABLE_SIZE + 1];

  for (genvar g = 0; g <= SHAPE_TABLE_SIZE; g++) begin : g_tbl
    localparam logic [SmoothW-1:0] Pt = denv_pkg::shape_point(g, SHAPE_TABLE_SIZE);
    assign shape_tbl[g] = Pt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= denv_pkg::ST_IDLE;
      pass_q  <= denv_pkg::POLE_FAST;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    pass_d   = pass_q;
    load_out = 1'b0;
    unique case (state_q)
      denv_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = denv_pkg::ST_RECT_MUL;
        end
      end
      denv_pkg::ST_RECT_MUL: state_d = denv_pkg::ST_RECT_SAT;
      denv_pkg::ST_RECT_SAT: begin
        pass_d  = denv_pkg::POLE_FAST;
        state_d = denv_pkg::ST_POLE_DIFF;
      end
      denv_pkg::ST_POLE_DIFF: state_d = denv_pkg::ST_POLE_MUL;
      denv_pkg::ST_POLE_MUL:  state_d = denv_pkg::ST_POLE_UPD;
      denv_pkg::ST_POLE_UPD: begin
        unique case (pass_q)
          denv_pkg::POLE_FAST: begin
            pass_d  = denv_pkg::POLE_SLOW;
            state_d = denv_pkg::ST_POLE_DIFF;
          end
          denv_pkg::POLE_SLOW:   state_d = denv_pkg::ST_ENV_MAX;
          denv_pkg::POLE_SMOOTH: state_d = denv_pkg::ST_DONE;
          default:               state_d = denv_pkg::ST_IDLE;
        endcase
      end
      denv_pkg::ST_ENV_MAX:     state_d = denv_pkg::ST_POS_MUL;
      denv_pkg::ST_POS_MUL:     state_d = denv_pkg::ST_TBL_LO;
      denv_pkg::ST_TBL_LO:      state_d = denv_pkg::ST_TBL_HI;
      denv_pkg::ST_TBL_HI:      state_d = denv_pkg::ST_INTERP_DIFF;
      denv_pkg::ST_INTERP_DIFF: state_d = denv_pkg::ST_INTERP_MUL;
      denv_pkg::ST_INTERP_MUL:  state_d = denv_pkg::ST_INTERP_ADD;
      denv_pkg::ST_INTERP_ADD:  state_d = denv_pkg::ST_SHAPE_DIFF;
      denv_pkg::ST_SHAPE_DIFF:  state_d = denv_pkg::ST_SHAPE_MUL;
      denv_pkg::ST_SHAPE_MUL:   state_d = denv_pkg::ST_SHAPE_ADD;
      denv_pkg::ST_SHAPE_ADD: begin
        pass_d  = denv_pkg::POLE_SMOOTH;
        state_d = denv_pkg::ST_POLE_DIFF;
      end
      denv_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = denv_pkg::ST_IDLE;
        end
      end
      default: state_d = denv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_gain_q    <= denv_pkg::SensGainReset;
      fast_att_q     <= denv_pkg::FastAttackReset;
      fast_rel_q     <= denv_pkg::FastReleaseReset;
      slow_att_q     <= denv_pkg::SlowAttackReset;
      slow_rel_q     <= denv_pkg::SlowReleaseReset;
      smooth_coef_q  <= denv_pkg::SmoothReset;
      shape_amount_q <= denv_pkg::ShapeAmountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        denv_pkg::CFG_SENS_GAIN:    sens_gain_q    <= cfg_data_i[denv_pkg::GainW-1:0];
        denv_pkg::CFG_FAST_ATTACK:  fast_att_q     <= cfg_data_i;
        denv_pkg::CFG_FAST_RELEASE: fast_rel_q     <= cfg_data_i;
        denv_pkg::CFG_SLOW_ATTACK:  slow_att_q     <= cfg_data_i;
        denv_pkg::CFG_SLOW_RELEASE: slow_rel_q     <= cfg_data_i;
        denv_pkg::CFG_SMOOTH:       smooth_coef_q  <= cfg_data_i;
        denv_pkg::CFG_SHAPE_AMOUNT: shape_amount_q <= cfg_data_i[denv_pkg::AmountW-1:0];
        default: ;
      endcase
    end
  end

  // Shared subtract and compare unit.
  always_comb begin
    unique case (pass_q)
      denv_pkg::POLE_FAST: begin
        pole_st  = fast_q;
        pole_tgt = rect_q;
        pole_lim = denv_pkg::LvlMax;
      end
      denv_pkg::POLE_SLOW: begin
        pole_st  = slow_q;
        pole_tgt = rect_q;
        pole_lim = denv_pkg::LvlMax;
      end
      default: begin
        pole_st  = LvlW'(smooth_q);
        pole_tgt = LvlW'(shaped_q);
        pole_lim = denv_pkg::LvlOne;
      end
    endcase

    unique case (state_q)
      denv_pkg::ST_POLE_DIFF: begin
        diff_x = pole_tgt;
        diff_y = pole_st;
      end
      denv_pkg::ST_INTERP_DIFF: begin
        diff_x = LvlW'(tbl_b_q);
        diff_y = LvlW'(tbl_a_q);
      end
      denv_pkg::ST_SHAPE_DIFF: begin
        diff_x = LvlW'(curve_q);
        diff_y = LvlW'(env_q);
      end
      default: begin
        diff_x = '0;
        diff_y = '0;
      end
    endcase
    diff_up  = diff_x >= diff_y;
    diff_abs = diff_up ? (diff_x - diff_y) : (diff_y - diff_x);

    unique case (pass_q)
      denv_pkg::POLE_FAST: coef_d = diff_up ? fast_att_q : fast_rel_q;
      denv_pkg::POLE_SLOW: coef_d = diff_up ? slow_att_q : slow_rel_q;
      default:             coef_d = smooth_coef_q;
    endcase
  end

  // Shared multiplier operand selection.
  always_comb begin
    amount = (shape_amount_q > denv_pkg::AmountFull) ? denv_pkg::AmountFull : shape_amount_q;
    unique case (state_q)
      denv_pkg::ST_RECT_MUL: begin
        mul_a = MulAW'(mag_q);
        mul_b = MulBW'(sens_gain_q);
      end
      denv_pkg::ST_POLE_MUL: begin
        mul_a = dabs_q;
        mul_b = coef_q;
      end
      denv_pkg::ST_POS_MUL: begin
        mul_a = MulAW'(env_q);
        mul_b = MulBW'(SHAPE_TABLE_SIZE);
      end
      denv_pkg::ST_INTERP_MUL: begin
        mul_a = dabs_q;
        mul_b = MulBW'(frac_q);
      end
      denv_pkg::ST_SHAPE_MUL: begin
        mul_a = dabs_q;
        mul_b = MulBW'(amount);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  end

  always_comb begin
    raw = sample_i;
    mag = raw[denv_pkg::SampleW-1] ? (~raw + 1'b1) : raw;

    rect_raw = prod_q >> denv_pkg::RectShift;
    rect_sat = (rect_raw > ProdW'(denv_pkg::LvlMax)) ? denv_pkg::LvlMax : rect_raw[LvlW-1:0];

    step_ext = SumW'(prod_q[ProdW-1:CoeffFracBits]);
    st_ext   = SumW'(pole_st);
    up_sum   = st_ext + step_ext;
    if (dir_q) begin
      pole_new = (up_sum > SumW'(pole_lim)) ? pole_lim : up_sum[LvlW-1:0];
    end else begin
      pole_new = (step_ext >= st_ext) ? '0 : pole_st - step_ext[LvlW-1:0];
    end

    env_max = (fast_q > slow_q) ? fast_q : slow_q;
    env_d   = (env_max > denv_pkg::LvlOne) ? SmoothOne : env_max[SmoothW-1:0];

    pos_idx = prod_q[LvlFrac +: IdxW];
    hi_addr = (idx_q == IdxLast) ? idx_q : idx_q + 1'b1;
    rd_addr = (state_q == denv_pkg::ST_TBL_LO) ? pos_idx : hi_addr;
    tbl_rd  = shape_tbl[rd_addr];

    ip_step = prod_q[ProdW-1:LvlFrac];
    ip_sum  = dir_q ? ((LvlW + 1)'(tbl_a_q) + (LvlW + 1)'(ip_step))
                    : ((LvlW + 1)'(tbl_a_q) - (LvlW + 1)'(ip_step));

    sh_step = (ShStepW + 1)'(prod_q[ProdW-1:AmountFrac]);
    sh_env  = (ShStepW + 1)'(env_q);
    sh_sum  = sh_env + sh_step;
    if (dir_q) begin
      shaped_d = (sh_sum > (ShStepW + 1)'(SmoothOne)) ? SmoothOne : sh_sum[SmoothW-1:0];
    end else begin
      shaped_d = (sh_step >= sh_env) ? '0 : env_q - sh_step[SmoothW-1:0];
    end

    out_sum = (SmoothW + 1)'(smooth_q) + (SmoothW + 1)'(denv_pkg::OutRound);
    rounded = out_sum[SmoothW:OutShift];
    env_out = (rounded > RoundW'(denv_pkg::EnvFull)) ? denv_pkg::EnvFull : rounded[EnvW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_q   <= '0;
      slow_q   <= '0;
      smooth_q <= '0;
    end else if (state_q == denv_pkg::ST_POLE_UPD) begin
      unique case (pass_q)
        denv_pkg::POLE_FAST:   fast_q   <= pole_new;
        denv_pkg::POLE_SLOW:   slow_q   <= pole_new;
        denv_pkg::POLE_SMOOTH: smooth_q <= pole_new[SmoothW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      denv_pkg::ST_IDLE:     mag_q  <= mag;
      denv_pkg::ST_RECT_SAT: rect_q <= rect_sat;
      denv_pkg::ST_POLE_DIFF: begin
        dir_q  <= diff_up;
        dabs_q <= diff_abs;
        coef_q <= coef_d;
      end
      denv_pkg::ST_ENV_MAX: env_q <= env_d;
      denv_pkg::ST_TBL_LO: begin
        idx_q   <= pos_idx;
        frac_q  <= prod_q[LvlFrac-1:0];
        tbl_a_q <= tbl_rd;
      end
      denv_pkg::ST_TBL_HI: tbl_b_q <= tbl_rd;
      denv_pkg::ST_INTERP_DIFF, denv_pkg::ST_SHAPE_DIFF: begin
        dir_q  <= diff_up;
        dabs_q <= diff_abs;
      end
      denv_pkg::ST_INTERP_ADD: curve_q  <= ip_sum[SmoothW-1:0];
      denv_pkg::ST_SHAPE_ADD:  shaped_q <= shaped_d;
      default: ;
    endcase
    if (load_out) begin
      out_q <= env_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign in_stall_o  = (state_q != denv_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign envelope_o  = out_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input accepted but the sequencer did not start.");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fast_q <= denv_pkg::LvlMax && slow_q <= denv_pkg::LvlMax && smooth_q <= SmoothOne)
    else $error("A follower state left its range.");

  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> envelope_o <= denv_pkg::EnvFull)
    else $error("Envelope exceeds full scale.");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == denv_pkg::ST_DONE))
    else $error("Result appeared outside the final step.");

  a_curve_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == denv_pkg::ST_SHAPE_DIFF |-> curve_q <= SmoothOne && env_q <= SmoothOne)
    else $error("Shaping curve or envelope above one.");
`endif

endmodule

`default_nettype wire

// ===== tb/dual_envelope_follower_unit_tb.sv =====
`timescale 1ns / 1ps

module dual_envelope_follower_unit_tb;
  import denv_pkg::*;

  localparam int ClkPeriod = 20;
  localparam int DrainCycles = 40;
  localparam int CycleLimit = 1_000_000;
  localparam int MaxReported = 10;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [SampleW-1:0] sample_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [EnvW-1:0] envelope_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  dual_envelope_follower_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .envelope_o  (envelope_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the configuration and follower state.
  logic [GainW-1:0] gain_reg = SensGainReset;
  logic [CoeffW-1:0] fast_attack = FastAttackReset;
  logic [CoeffW-1:0] fast_release = FastReleaseReset;
  logic [CoeffW-1:0] slow_attack = SlowAttackReset;
  logic [CoeffW-1:0] slow_release = SlowReleaseReset;
  logic [CoeffW-1:0] smooth_coeff = SmoothReset;
  logic [AmountW-1:0] amount_reg = ShapeAmountReset;
  logic [LvlW-1:0] fast_lvl = '0;
  logic [LvlW-1:0] slow_lvl = '0;
  logic [SmoothW-1:0] smooth_lvl = '0;

  logic [63:0] tanh_curve [0:ShapeTableSize];
  logic [EnvW-1:0] expected_envelopes [$];
  logic [EnvW-1:0] oldest_envelope;

  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic logic [63:0] exp_series(input logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] n;
    sum = ExpOne;
    term = ExpOne;
    for (n = 64'd1; n < 64'd64 && term != 64'd0; n++) begin
      term = ((term * z) >> ExpFrac) / n;
      sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [63:0] half_tanh(input logic [63:0] z);
    logic [63:0] e;
    e = exp_series(z);
    return ((e - 64'd1) << ExpFrac) / (e + 64'd1);
  endfunction

  function automatic void build_tanh_curve();
    logic [63:0] t_end;
    logic [63:0] z;
    logic [63:0] v;
    int i;
    t_end = half_tanh(64'd3 << ExpFrac);
    for (i = 0; i <= ShapeTableSize; i++) begin
      z = ((64'd3 << ExpFrac) * 64'(i)) / 64'(ShapeTableSize);
      v = ((half_tanh(z) << LvlFrac) + t_end / 64'd2) / t_end;
      if (v > 64'(LvlOne)) v = 64'(LvlOne);
      tanh_curve[i] = v;
    end
    tanh_curve[0] = 64'd0;
    tanh_curve[ShapeTableSize] = 64'(LvlOne);
  endfunction

  function automatic logic [63:0] pole_step(input logic [63:0] level, input logic [63:0] target,
                                            input logic [63:0] coeff, input logic [63:0] limit);
    logic [63:0] sum;
    logic [63:0] step;
    if (target >= level) begin
      sum = level + ((coeff * (target - level)) >> CoeffFracBits);
      return (sum > limit) ? limit : sum;
    end else begin
      step = (coeff * (level - target)) >> CoeffFracBits;
      return (step >= level) ? 64'd0 : level - step;
    end
  endfunction

  function automatic logic [EnvW-1:0] predict_envelope(input logic [SampleW-1:0] raw);
    logic [63:0] mag, rect, coeff, lvl_env, pos, idx, frac, a, b, curve;
    logic [63:0] amount, step, shaped, smoothed, res;
    mag = raw[SampleW-1] ? (64'h1_0000 - 64'(raw)) : 64'(raw);
    rect = (mag * 64'(gain_reg)) >> RectShift;
    if (rect > 64'(LvlMax)) rect = 64'(LvlMax);

    coeff = (rect > 64'(fast_lvl)) ? 64'(fast_attack) : 64'(fast_release);
    fast_lvl = LvlW'(pole_step(64'(fast_lvl), rect, coeff, 64'(LvlMax)));
    coeff = (rect > 64'(slow_lvl)) ? 64'(slow_attack) : 64'(slow_release);
    slow_lvl = LvlW'(pole_step(64'(slow_lvl), rect, coeff, 64'(LvlMax)));

    lvl_env = (fast_lvl > slow_lvl) ? 64'(fast_lvl) : 64'(slow_lvl);
    if (lvl_env > 64'(LvlOne)) lvl_env = 64'(LvlOne);

    pos = lvl_env * 64'(ShapeTableSize);
    idx = pos >> LvlFrac;
    frac = pos & ((64'd1 << LvlFrac) - 64'd1);
    if (idx >= 64'(ShapeTableSize)) begin
      curve = tanh_curve[ShapeTableSize];
    end else begin
      a = tanh_curve[idx];
      b = tanh_curve[idx + 1];
      curve = (b >= a) ? a + (((b - a) * frac) >> LvlFrac) : a - (((a - b) * frac) >> LvlFrac);
    end

    amount = (amount_reg > AmountFull) ? 64'(AmountFull) : 64'(amount_reg);
    if (curve >= lvl_env) begin
      step = (amount * (curve - lvl_env)) >> AmountFrac;
      shaped = lvl_env + step;
      if (shaped > 64'(LvlOne)) shaped = 64'(LvlOne);
    end else begin
      step = (amount * (lvl_env - curve)) >> AmountFrac;
      shaped = (step >= lvl_env) ? 64'd0 : lvl_env - step;
    end

    smoothed = pole_step(64'(smooth_lvl), shaped, 64'(smooth_coeff), 64'(LvlOne));
    smooth_lvl = SmoothW'(smoothed);
    res = (smoothed + 64'(OutRound)) >> OutShift;
    if (res > 64'(EnvFull)) res = 64'(EnvFull);
    return EnvW'(res);
  endfunction

  function automatic logic [CfgW-1:0] random_coeff();
    case ($urandom_range(0, 7))
      0: return CfgW'($urandom);
      1: return '0;
      2: return '1;
      default: return CfgW'($urandom_range(1, 1 << 18));
    endcase
  endfunction

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("dual_envelope_follower_unit_tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_envelopes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReported) begin
          $display("Unexpected envelope transaction: got %0d.", envelope_o);
        end
      end else begin
        oldest_envelope = expected_envelopes.pop_front();
        if (envelope_o !== oldest_envelope) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("Envelope mismatch: expected %0d, got %0d.", oldest_envelope, envelope_o);
          end
        end
      end
    end
  end

  task automatic send_sample(input logic [SampleW-1:0] value);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= value;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_envelopes.push_back(predict_envelope(value));
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_envelopes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SENS_GAIN:    gain_reg = data[GainW-1:0];
      CFG_FAST_ATTACK:  fast_attack = data[CoeffW-1:0];
      CFG_FAST_RELEASE: fast_release = data[CoeffW-1:0];
      CFG_SLOW_ATTACK:  slow_attack = data[CoeffW-1:0];
      CFG_SLOW_RELEASE: slow_release = data[CoeffW-1:0];
      CFG_SMOOTH:       smooth_coeff = data[CoeffW-1:0];
      CFG_SHAPE_AMOUNT: amount_reg = data[AmountW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic randomize_settings();
    logic [CfgW-1:0] data;
    int k;
    case ($urandom_range(0, 3))
      0: data = CfgW'($urandom_range(0, 65535));
      1: data = CfgW'(SensGainReset);
      2: data = CfgW'($urandom_range(16384, 65535));
      default: data = CfgW'($urandom);
    endcase
    write_reg(CFG_SENS_GAIN, data);
    for (k = CFG_FAST_ATTACK; k <= CFG_SMOOTH; k++) begin
      write_reg(CfgIdxW'(k), random_coeff());
    end
    case ($urandom_range(0, 3))
      0: data = '0;
      1: data = CfgW'(AmountFull);
      2: data = CfgW'($urandom_range(0, 65536));
      default: data = CfgW'($urandom);
    endcase
    write_reg(CFG_SHAPE_AMOUNT, data);
    write_reg(CfgIdxUnused, CfgW'($urandom));
  endtask

  task automatic test_default_settings();
    logic [SampleW-1:0] points [10] = '{16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                                        16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA, 16'h0000};
    int i;
    for (i = 0; i < 10; i++) send_sample(points[i]);
    wait_for_drain();
  endtask

  task automatic test_register_extremes();
    int k;
    // All-ones writes set every register to full scale; the shape amount is clamped to one.
    write_reg(CFG_SENS_GAIN, '1);
    for (k = CFG_FAST_ATTACK; k <= CFG_SMOOTH; k++) write_reg(CfgIdxW'(k), '1);
    write_reg(CFG_SHAPE_AMOUNT, '1);
    write_reg(CfgIdxUnused, '0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    send_sample(16'd100);
    send_sample(-16'sd100);
    wait_for_drain();

    write_reg(CFG_SENS_GAIN, '0);
    for (k = CFG_FAST_ATTACK; k <= CFG_SMOOTH; k++) write_reg(CfgIdxW'(k), '0);
    write_reg(CFG_SHAPE_AMOUNT, CfgW'(AmountFull));
    write_reg(CfgIdxUnused, '1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    wait_for_drain();

    write_reg(CFG_SENS_GAIN, 24'h01_2000);
    write_reg(CFG_FAST_ATTACK, 24'h80_0000);
    write_reg(CFG_FAST_RELEASE, 24'h10_0000);
    write_reg(CFG_SLOW_ATTACK, 24'h08_0000);
    write_reg(CFG_SLOW_RELEASE, 24'h01_0000);
    write_reg(CFG_SMOOTH, 24'h40_0000);
    write_reg(CFG_SHAPE_AMOUNT, 24'h00_FFFF);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h4000);
    send_sample(16'h0000);
    wait_for_drain();
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int item_total);
    int blk;
    int sent;
    int seg_len;
    int amp;
    int v;
    int j;
    send_idle_pct = sender_pct;
    recv_stall_pct = receiver_pct;
    for (blk = 0; blk < 2; blk++) begin
      wait_for_drain();
      randomize_settings();
      sent = 0;
      while (sent < item_total / 2) begin
        seg_len = $urandom_range(4, 60);
        case ($urandom_range(0, 4))
          0: amp = 32768;
          1: amp = $urandom_range(1024, 32768);
          2: amp = $urandom_range(1, 512);
          3: amp = 0;
          default: amp = 8192;
        endcase
        for (j = 0; j < seg_len && sent < item_total / 2; j++) begin
          if ($urandom_range(0, 15) == 0) begin
            v = $urandom_range(0, 1) ? 32767 : -32768;
          end else begin
            v = int'($urandom_range(0, 2 * amp)) - amp;
            if (v > 32767) v = 32767;
          end
          send_sample(SampleW'(v));
          sent++;
        end
      end
    end
    wait_for_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    build_tanh_curve();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_settings();
    test_register_extremes();
    test_random_traffic(27, 84, 610);
    test_random_traffic(84, 27, 610);
    test_random_traffic(0, 0, 610);

    if (mismatch_count == 0 && expected_envelopes.size() == 0) begin
      $display("dual_envelope_follower_unit_tb: clean");
    end else begin
      $display("dual_envelope_follower_unit_tb: errors");
    end
    $finish;
  end

endmodule
